// ===== src/vet_pkg.sv =====
// ----------------------------------------------------------------------------
// vet_pkg: shared types and constants of the voice envelope table
// Action and result codes, register indexes, reset values, the voice record
// and the velocity-to-amplitude table.
// ----------------------------------------------------------------------------
package vet_pkg;

   localparam int VOICES_DEFAULT = 32;
   localparam int KEYS           = 128;

   // Input actions.
   localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
   localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
   localparam logic [1:0] ACT_TICK     = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_ADDED    = 2'd0;
   localparam logic [1:0] KIND_DROPPED  = 2'd1;
   localparam logic [1:0] KIND_RELEASED = 2'd2;
   localparam logic [1:0] KIND_LISTING  = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] CSR_SAMPLE_MODE    = 3'd0;
   localparam logic [2:0] CSR_HELD_DECAY     = 3'd1;
   localparam logic [2:0] CSR_RELEASED_DECAY = 3'd2;
   localparam logic [2:0] CSR_SAMPLE_DECAY   = 3'd3;
   localparam logic [2:0] CSR_THRESHOLD      = 3'd4;

   // Register reset values (Q0.16 where applicable).
   localparam logic        SAMPLE_MODE_RST    = 1'b1;
   localparam logic [15:0] HELD_DECAY_RST     = 16'd65503;
   localparam logic [15:0] RELEASED_DECAY_RST = 16'd64881;
   localparam logic [15:0] SAMPLE_DECAY_RST   = 16'd65208;
   localparam logic [15:0] THRESHOLD_RST      = 16'd66;

   localparam logic [31:0] ROUND_HALF = 32'd32768;

   typedef struct packed {
      logic [6:0]  key;
      logic [15:0] amp;
      logic        sampled;
   } voice_type;

   typedef struct packed {
      logic shift;
      logic load;
   } chain_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREFETCH,
      ST_DECAY,
      ST_LIST
   } vet_state_type;

   typedef logic [KEYS-1:0][15:0] amp_table_type;

   // (v/127)^2 in Q0.16, rounded to nearest, saturated to 16 bits.
   function automatic amp_table_type build_amp_table();
      amp_table_type t;
      int            q;
      for (int v = 0; v < KEYS; v++) begin
         q = (v * v * 65536 + 8064) / 16129;
         t[v] = (q > 65535) ? 16'hFFFF : 16'(q);
      end
      return t;
   endfunction

   localparam amp_table_type VEL_AMP = build_amp_table();

endpackage

// ===== src/voice_envelope_table.sv =====
// ----------------------------------------------------------------------------
// voice_envelope_table: polyphonic voice table with a per-tick decay envelope
// Takes note-on, note-off and tick commands, keeps held keys and an ordered
// table of decaying voices, and reports added, dropped, released and listed
// voices.
// ----------------------------------------------------------------------------
// Usage. A command transaction is taken at a rising edge with start high and
// busy low; req_action selects note-on, note-off or tick. Each result
// transaction is shown on the rsp_ ports for one cycle with rsp_valid high,
// and rsp_last marks the final result of a command. The receiver cannot
// stall: results are never held back.
// Note events never raise busy: their single result appears in the cycle
// after acceptance and a new command can follow in the next cycle. An unknown
// action is dropped without a result and never raises busy either. A tick on
// an empty table answers like a note event with one empty listing. A tick on
// a nonempty table first fetches the held flag of the head voice, then passes
// the voices one at a time through the shared decay multiplier, then lists
// the survivors or, if none is left, gives one empty listing; busy stays high
// throughout, and each result is registered before it is shown.
// Configuration transactions on the csr_ channel are always ready; the user
// must issue them only while the block is idle, as the block does not
// enforce it. Reset empties the voice table, releases every key and
// restores the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module voice_envelope_table #(
   parameter int VOICES = vet_pkg::VOICES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Command channel.
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [6:0]  req_key,
   input  logic [6:0]  req_velocity,
   // Result channel.
   output logic        rsp_valid,
   output logic [1:0]  rsp_result_kind,
   output logic [6:0]  rsp_voice_key,
   output logic [15:0] rsp_amplitude,
   output logic        rsp_sampled,
   output logic [5:0]  rsp_voice_count,
   output logic        rsp_last,
   // Configuration channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import vet_pkg::*;

   localparam int CNT_W = $clog2(VOICES + 1);
   localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

   // Configuration registers.
   logic        sample_mode_ff;
   logic [15:0] held_decay_ff;
   logic [15:0] released_decay_ff;
   logic [15:0] sample_decay_ff;
   logic [15:0] threshold_ff;

   // Control state. count_ff is the number of voices in the chain; during
   // the decay pass it counts unprocessed voices plus survivors so far.
   vet_state_type    state_ff,  state_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [CNT_W-1:0] rem_ff,    rem_in;

   // Result register.
   logic        rsp_valid_ff,  rsp_valid_in;
   logic [1:0]  rsp_kind_ff,   rsp_kind_in;
   logic [6:0]  rsp_key_ff,    rsp_key_in;
   logic [15:0] rsp_amp_ff,    rsp_amp_in;
   logic        rsp_smp_ff,    rsp_smp_in;
   logic [5:0]  rsp_count_ff,  rsp_count_in;
   logic        rsp_last_ff,   rsp_last_in;

   // Chain and held-key map connections.
   chain_ctrl_type   chain_ctrl;
   logic [IDX_W-1:0] load_idx;
   voice_type        load_data;
   voice_type        head;
   voice_type        next;
   logic             held_wr_en;
   logic             held_wr_value;
   logic [6:0]       held_rd_key;
   logic             head_held;

   // Decay datapath for the voice at the head of the chain.
   logic        accept;
   logic        do_decay;
   logic [15:0] factor;
   logic [31:0] product;
   logic [15:0] new_amp;
   logic        survives;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_mode_ff    <= SAMPLE_MODE_RST;
         held_decay_ff     <= HELD_DECAY_RST;
         released_decay_ff <= RELEASED_DECAY_RST;
         sample_decay_ff   <= SAMPLE_DECAY_RST;
         threshold_ff      <= THRESHOLD_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SAMPLE_MODE:    sample_mode_ff    <= csr_data[0];
            CSR_HELD_DECAY:     held_decay_ff     <= csr_data;
            CSR_RELEASED_DECAY: released_decay_ff <= csr_data;
            CSR_SAMPLE_DECAY:   sample_decay_ff   <= csr_data;
            CSR_THRESHOLD:      threshold_ff      <= csr_data;
            default: begin
            end
         endcase
      end
   end

   vet_chain #(
      .VOICES (VOICES),
      .IDX_W  (IDX_W)
   ) u_chain (
      .clock     (clock),
      .ctrl      (chain_ctrl),
      .load_idx  (load_idx),
      .load_data (load_data),
      .head      (head),
      .next      (next)
   );

   vet_held u_held (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (held_wr_en),
      .wr_key   (req_key),
      .wr_value (held_wr_value),
      .rd_key   (held_rd_key),
      .rd_held  (head_held)
   );

   // An unsampled voice decays by the held or released factor. A sampled
   // voice decays only once its key is released. The product plus one half
   // never exceeds 32 bits, so the upper half is the rounded result.
   always_comb begin
      do_decay = !head.sampled || !head_held;
      if (head.sampled) begin
         factor = sample_decay_ff;
      end else if (head_held) begin
         factor = held_decay_ff;
      end else begin
         factor = released_decay_ff;
      end
      product  = {16'd0, head.amp} * {16'd0, factor} + ROUND_HALF;
      new_amp  = do_decay ? product[31:16] : head.amp;
      survives = (new_amp >= threshold_ff);
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      chain_ctrl    = '0;
      load_idx      = IDX_W'(count_ff - CNT_W'(1));
      load_data     = head;
      held_wr_en    = 1'b0;
      held_wr_value = 1'b0;
      held_rd_key   = head.key;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = KIND_LISTING;
      rsp_key_in    = '0;
      rsp_amp_in    = '0;
      rsp_smp_in    = 1'b0;
      rsp_last_in   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_action == ACT_NOTE_ON && req_velocity != 7'd0) begin
                  held_wr_en    = 1'b1;
                  held_wr_value = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_key_in    = req_key;
                  rsp_last_in   = 1'b1;
                  if (count_ff < CNT_W'(VOICES)) begin
                     // Append the new voice behind the last one.
                     chain_ctrl.load   = 1'b1;
                     load_idx          = IDX_W'(count_ff);
                     load_data.key     = req_key;
                     load_data.amp     = VEL_AMP[req_velocity];
                     load_data.sampled = sample_mode_ff;
                     count_in          = count_ff + CNT_W'(1);
                     rsp_kind_in       = KIND_ADDED;
                     rsp_amp_in        = VEL_AMP[req_velocity];
                     rsp_smp_in        = sample_mode_ff;
                  end else begin
                     rsp_kind_in = KIND_DROPPED;
                  end
               end else if (req_action == ACT_NOTE_ON || req_action == ACT_NOTE_OFF) begin
                  held_wr_en   = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_RELEASED;
                  rsp_key_in   = req_key;
                  rsp_last_in  = 1'b1;
               end else if (req_action == ACT_TICK) begin
                  if (count_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                  end else begin
                     state_in = ST_PREFETCH;
                     rem_in   = count_ff;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_PREFETCH: begin
            // The held flag of the head voice is read during this cycle.
            state_in = ST_DECAY;
         end

         ST_DECAY: begin
            // Pop the head, push it back at the tail end if it survives,
            // and fetch the held flag of the voice that moves up next.
            held_rd_key       = next.key;
            chain_ctrl.shift  = 1'b1;
            chain_ctrl.load   = survives;
            load_data.amp     = new_amp;
            count_in          = count_ff - CNT_W'(1) + CNT_W'(survives);
            rem_in            = rem_ff - CNT_W'(1);
            if (rem_ff == CNT_W'(1)) begin
               if (count_in == '0) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
               end else begin
                  state_in = ST_LIST;
                  rem_in   = count_in;
               end
            end
         end

         ST_LIST: begin
            // Rotate the chain once, reporting each voice as it passes.
            chain_ctrl.shift = 1'b1;
            chain_ctrl.load  = 1'b1;
            rsp_valid_in     = 1'b1;
            rsp_key_in       = head.key;
            rsp_amp_in       = head.amp;
            rsp_smp_in       = head.sampled;
            rem_in           = rem_ff - CNT_W'(1);
            if (rem_ff == CNT_W'(1)) begin
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_count_in = 6'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_amp_ff   <= rsp_amp_in;
      rsp_smp_ff   <= rsp_smp_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_voice_key   = rsp_key_ff;
   assign rsp_amplitude   = rsp_amp_ff;
   assign rsp_sampled     = rsp_smp_ff;
   assign rsp_voice_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   // The voice count never exceeds the number of slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(VOICES))
      else $error("voice count exceeds the table size");

   // During the decay pass the unprocessed voices are part of the count.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECAY) |-> (rem_ff != '0 && rem_ff <= count_ff))
      else $error("decay pass counter out of range");

   // Listing only runs over a nonempty table.
   a_list_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LIST) |-> (count_ff != '0 && rem_ff <= count_ff))
      else $error("listing over an empty table");

   // A tick on an empty table answers at once with one empty listing.
   a_empty_tick: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ACT_TICK && count_ff == '0) |=>
         (rsp_valid && rsp_last && rsp_voice_count == 6'd0 && !busy))
      else $error("empty tick did not give a single empty listing");
`endif

endmodule

// ===== src/vet_cell.sv =====
// ----------------------------------------------------------------------------
// vet_cell: one voice slot of the chain
// Holds one voice record; takes a new record, its neighbor's record, or holds.
// ----------------------------------------------------------------------------
module vet_cell (
   input  logic              clock,
   input  logic              shift,
   input  logic              load,
   input  vet_pkg::voice_type neighbor,
   input  vet_pkg::voice_type load_data,
   output vet_pkg::voice_type q
);
   import vet_pkg::*;

   voice_type voice_ff;
   voice_type voice_in;

   // A load wins over the shift: it fills the slot freed at the tail end.
   always_comb begin
      priority if (load) begin
         voice_in = load_data;
      end else if (shift) begin
         voice_in = neighbor;
      end else begin
         voice_in = voice_ff;
      end
   end

   always_ff @(posedge clock) begin
      voice_ff <= voice_in;
   end

   assign q = voice_ff;

endmodule

// ===== src/vet_held.sv =====
// ----------------------------------------------------------------------------
// vet_held: map of held keys
// One flag per key, cleared by reset, with one write port and a registered
// read port.
// ----------------------------------------------------------------------------
module vet_held (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  logic [6:0] wr_key,
   input  logic       wr_value,
   input  logic [6:0] rd_key,
   output logic       rd_held
);
   import vet_pkg::*;

   logic [KEYS-1:0] held_ff;
   logic            rd_held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (wr_en) begin
         held_ff[wr_key] <= wr_value;
      end
   end

   always_ff @(posedge clock) begin
      rd_held_ff <= held_ff[rd_key];
   end

   assign rd_held = rd_held_ff;

endmodule

// ===== src/vet_chain.sv =====
// ----------------------------------------------------------------------------
// vet_chain: ordered row of voice slots
// Slot 0 is the head. A shift moves every slot one place toward the head,
// and a load writes one slot chosen by index.
// ----------------------------------------------------------------------------
module vet_chain #(
   parameter int VOICES = vet_pkg::VOICES_DEFAULT,
   parameter int IDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1
) (
   input  logic                   clock,
   input  vet_pkg::chain_ctrl_type ctrl,
   input  logic [IDX_W-1:0]       load_idx,
   input  vet_pkg::voice_type     load_data,
   output vet_pkg::voice_type     head,
   output vet_pkg::voice_type     next
);
   import vet_pkg::*;

   voice_type cell_q [VOICES];

   for (genvar i = 0; i < VOICES; i++) begin : g_cell
      voice_type nb;
      logic      ld;

      if (i < VOICES - 1) begin : g_inner
         assign nb = cell_q[i+1];
      end else begin : g_tail
         assign nb = cell_q[i];
      end

      assign ld = ctrl.load && (load_idx == IDX_W'(i));

      vet_cell u_cell (
         .clock     (clock),
         .shift     (ctrl.shift),
         .load      (ld),
         .neighbor  (nb),
         .load_data (load_data),
         .q         (cell_q[i])
      );
   end

   assign head = cell_q[0];

   if (VOICES > 1) begin : g_next
      assign next = cell_q[1];
   end else begin : g_next_single
      assign next = cell_q[0];
   end

endmodule

// ===== bench/voice_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_table_checker: result checker for the voice envelope table
// Keeps its own copy of the held keys, the voice table and the registers,
// predicts the result transactions of every accepted command and compares
// them in order against the result channel.
// ----------------------------------------------------------------------------
module voice_table_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_action,
   input  logic [6:0]  req_key,
   input  logic [6:0]  req_velocity,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_result_kind,
   input  logic [6:0]  rsp_voice_key,
   input  logic [15:0] rsp_amplitude,
   input  logic        rsp_sampled,
   input  logic [5:0]  rsp_voice_count,
   input  logic        rsp_last,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          mismatch_count,
   output int          results_due
);

   import vet_pkg::*;

   localparam int SLOTS = VOICES_DEFAULT;

   typedef struct packed {
      logic [1:0]  kind;
      logic [6:0]  key;
      logic [15:0] amp;
      logic        sampled;
      logic [5:0]  count;
      logic        last;
   } voice_report_type;

   logic            mode_sampled;
   logic [15:0]     held_factor;
   logic [15:0]     released_factor;
   logic [15:0]     sample_factor;
   logic [15:0]     floor_level;
   logic [KEYS-1:0] key_down;
   voice_type       slot [SLOTS];
   int              live;
   int              errors = 0;
   voice_report_type due_q [$];

   function automatic logic [15:0] velocity_amp(input logic [6:0] vel);
      int q;
      q = (int'(vel) * int'(vel) * 65536 + 8064) / 16129;
      return (q > 65535) ? 16'hFFFF : 16'(q);
   endfunction

   // Rounded Q0.16 product; the upper half always fits in 16 bits.
   function automatic logic [15:0] decayed(input logic [15:0] amp, input logic [15:0] factor);
      logic [63:0] p;
      p = 64'(amp) * 64'(factor) + 64'(ROUND_HALF);
      return p[31:16];
   endfunction

   function automatic voice_report_type make_report(input logic [1:0] kind,
                                                    input logic [6:0] key,
                                                    input logic [15:0] amp,
                                                    input logic sampled,
                                                    input logic last);
      voice_report_type r;
      r.kind    = kind;
      r.key     = key;
      r.amp     = amp;
      r.sampled = sampled;
      r.count   = 6'(live);
      r.last    = last;
      return r;
   endfunction

   task automatic advance_voice_table(input logic [1:0] action, input logic [6:0] key,
                                      input logic [6:0] vel);
      int   n;
      logic down;
      if ((action == ACT_NOTE_ON) && (vel != '0)) begin
         key_down[key] = 1'b1;
         if (live < SLOTS) begin
            slot[live].key     = key;
            slot[live].amp     = velocity_amp(vel);
            slot[live].sampled = mode_sampled;
            live++;
            due_q.push_back(make_report(KIND_ADDED, key, velocity_amp(vel), mode_sampled,
                                        1'b1));
         end else begin
            due_q.push_back(make_report(KIND_DROPPED, key, '0, 1'b0, 1'b1));
         end
      end else if ((action == ACT_NOTE_ON) || (action == ACT_NOTE_OFF)) begin
         key_down[key] = 1'b0;
         due_q.push_back(make_report(KIND_RELEASED, key, '0, 1'b0, 1'b1));
      end else if (action == ACT_TICK) begin
         // Decay every voice first, then squeeze out the quiet ones in order.
         for (int i = 0; i < live; i++) begin
            down = key_down[slot[i].key];
            if (!slot[i].sampled) begin
               slot[i].amp = decayed(slot[i].amp, down ? held_factor : released_factor);
            end else if (!down) begin
               slot[i].amp = decayed(slot[i].amp, sample_factor);
            end
         end
         n = 0;
         for (int i = 0; i < live; i++) begin
            if (slot[i].amp >= floor_level) begin
               slot[n] = slot[i];
               n++;
            end
         end
         live = n;
         if (n == 0) begin
            due_q.push_back(make_report(KIND_LISTING, '0, '0, 1'b0, 1'b1));
         end else begin
            for (int i = 0; i < n; i++) begin
               due_q.push_back(make_report(KIND_LISTING, slot[i].key, slot[i].amp,
                                           slot[i].sampled, i == n - 1));
            end
         end
      end
   endtask

   task automatic check_report();
      voice_report_type seen;
      voice_report_type want;
      seen.kind    = rsp_result_kind;
      seen.key     = rsp_voice_key;
      seen.amp     = rsp_amplitude;
      seen.sampled = rsp_sampled;
      seen.count   = rsp_voice_count;
      seen.last    = rsp_last;
      if (due_q.size() == 0) begin
         errors++;
         if (errors <= 10) begin
            $display("%0t: unexpected result transaction kind %0d key %0d amp %0d",
                     $realtime, seen.kind, seen.key, seen.amp);
         end
      end else begin
         want = due_q.pop_front();
         if ((seen.kind !== want.kind) || (seen.key !== want.key) ||
             (seen.amp !== want.amp) || (seen.sampled !== want.sampled) ||
             (seen.count !== want.count) || (seen.last !== want.last)) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: result mismatch, expected kind %0d key %0d amp %0d smp %0d cnt %0d last %0d",
                        $realtime, want.kind, want.key, want.amp, want.sampled,
                        want.count, want.last);
               $display("%0t:                   got kind %0d key %0d amp %0d smp %0d cnt %0d last %0d",
                        $realtime, seen.kind, seen.key, seen.amp, seen.sampled,
                        seen.count, seen.last);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode_sampled    = SAMPLE_MODE_RST;
         held_factor     = HELD_DECAY_RST;
         released_factor = RELEASED_DECAY_RST;
         sample_factor   = SAMPLE_DECAY_RST;
         floor_level     = THRESHOLD_RST;
         key_down        = '0;
         live            = 0;
         due_q.delete();
      end else begin
         // A result never belongs to a command taken at the same edge.
         if (rsp_valid) begin
            check_report();
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SAMPLE_MODE:    mode_sampled    = csr_data[0];
               CSR_HELD_DECAY:     held_factor     = csr_data;
               CSR_RELEASED_DECAY: released_factor = csr_data;
               CSR_SAMPLE_DECAY:   sample_factor   = csr_data;
               CSR_THRESHOLD:      floor_level     = csr_data;
               default: ;
            endcase
         end
         if (start && !busy) begin
            advance_voice_table(req_action, req_key, req_velocity);
         end
      end
      mismatch_count <= errors;
      results_due    <= due_q.size();
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the voice envelope table
// Drives note-on, note-off, tick and unknown commands under several register
// settings, with random idle gaps, while a checker beside the block predicts
// and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_top;

   import vet_pkg::*;

   // The package has no name for the fourth action code; the block ignores it.
   localparam logic [1:0] ACT_UNKNOWN = 2'd3;

   localparam int RESET_CYCLES = 9;
   // The slowest item is a tick over a full table plus an idle gap; about 430
   // items are run in all.
   localparam int CYCLE_LIMIT  = 300000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [1:0]  req_action = ACT_NOTE_ON;
   logic [6:0]  req_key = '0;
   logic [6:0]  req_velocity = '0;
   logic        csr_valid = 1'b0;
   logic [2:0]  csr_index = CSR_SAMPLE_MODE;
   logic [15:0] csr_data = '0;

   logic        busy;
   logic        rsp_valid;
   logic [1:0]  rsp_result_kind;
   logic [6:0]  rsp_voice_key;
   logic [15:0] rsp_amplitude;
   logic        rsp_sampled;
   logic [5:0]  rsp_voice_count;
   logic        rsp_last;
   logic        csr_ready;

   int          mismatch_count;
   int          results_due;
   int          cycle_count = 0;
   // While set, the command and register sides never idle.
   logic        calm = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   voice_envelope_table u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_key         (req_key),
      .req_velocity    (req_velocity),
      .rsp_valid       (rsp_valid),
      .rsp_result_kind (rsp_result_kind),
      .rsp_voice_key   (rsp_voice_key),
      .rsp_amplitude   (rsp_amplitude),
      .rsp_sampled     (rsp_sampled),
      .rsp_voice_count (rsp_voice_count),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   voice_table_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_key         (req_key),
      .req_velocity    (req_velocity),
      .rsp_valid       (rsp_valid),
      .rsp_result_kind (rsp_result_kind),
      .rsp_voice_key   (rsp_voice_key),
      .rsp_amplitude   (rsp_amplitude),
      .rsp_sampled     (rsp_sampled),
      .rsp_voice_count (rsp_voice_count),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .results_due     (results_due)
   );

   // A hung handshake or a result that never comes ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // About 37 transactions in a hundred are preceded by an idle gap. A gap
   // that follows a tick can end while the tick is still under way, so start
   // is then raised while busy is high.
   function automatic int pick_gap();
      if (calm || ($urandom_range(99) >= 37)) begin
         return 0;
      end
      return $urandom_range(1, 12);
   endfunction

   // Offers one command transaction and returns at the edge that takes it.
   // Start is left high, so the next call either keeps it high for a
   // back-to-back transaction or lowers it for a gap: never both in one step.
   task automatic issue_command(input logic [1:0] action, input logic [6:0] key,
                                input logic [6:0] vel);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_action   <= action;
      req_key      <= key;
      req_velocity <= vel;
      do begin
         @(posedge clock);
      end while (busy);
   endtask

   // Register writes follow the same pattern as commands; csr_valid is
   // lowered by the caller once the whole batch has gone through.
   task automatic write_register(input logic [2:0] index, input logic [15:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         csr_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do begin
         @(posedge clock);
      end while (!csr_ready);
   endtask

   // Stops offering commands and waits until every predicted result has come
   // back. An ignored command gives no result, so a few more cycles pass to
   // let the block return to idle before the registers are touched.
   task automatic drain_block();
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (results_due != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_envelope(input logic mode, input logic [15:0] held,
                                   input logic [15:0] released, input logic [15:0] sampled,
                                   input logic [15:0] threshold);
      drain_block();
      write_register(CSR_SAMPLE_MODE, {15'd0, mode});
      write_register(CSR_HELD_DECAY, held);
      write_register(CSR_RELEASED_DECAY, released);
      write_register(CSR_SAMPLE_DECAY, sampled);
      write_register(CSR_THRESHOLD, threshold);
      csr_valid <= 1'b0;
   endtask

   // Random commands. Keys mostly come from a narrow band so that releases
   // hit keys that own voices; one in four spans the whole key range. Ignored
   // commands are thrown in as noise and do not count toward the total.
   task automatic play_random(input int count);
      int         done;
      int         pick;
      logic [1:0] action;
      logic [6:0] key;
      logic [6:0] vel;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(99);
         key  = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(56, 71));
         vel  = 7'($urandom_range(1, 127));
         if (pick < 45) begin
            action = ACT_NOTE_ON;
         end else if (pick < 58) begin
            action = ACT_NOTE_OFF;
            vel    = 7'($urandom_range(127));
         end else if (pick < 63) begin
            action = ACT_NOTE_ON;
            vel    = '0;
         end else if (pick < 95) begin
            action = ACT_TICK;
            key    = 7'($urandom);
            vel    = 7'($urandom);
         end else begin
            action = ACT_UNKNOWN;
            key    = 7'($urandom);
            vel    = 7'($urandom);
         end
         issue_command(action, key, vel);
         if (action != ACT_UNKNOWN) begin
            done++;
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset register values, so new voices are
      // sampled. A tick on an empty table lists nothing but the empty marker.
      issue_command(ACT_TICK, 7'd0, 7'd0);
      // The unknown action is ignored, even with every field at its maximum.
      issue_command(ACT_UNKNOWN, 7'd127, 7'd127);
      // Smallest and largest velocity on the lowest and highest keys.
      issue_command(ACT_NOTE_ON, 7'd0, 7'd1);
      issue_command(ACT_NOTE_ON, 7'd127, 7'd127);
      issue_command(ACT_NOTE_ON, 7'd64, 7'd64);
      // A note-on with zero velocity releases its key.
      issue_command(ACT_NOTE_ON, 7'd64, 7'd0);
      // Held sampled voices keep their level; the released one decays and the
      // quietest voice falls under the threshold and is removed.
      issue_command(ACT_TICK, 7'd0, 7'd0);
      issue_command(ACT_NOTE_OFF, 7'd127, 7'd127);
      issue_command(ACT_NOTE_OFF, 7'd5, 7'd0);
      issue_command(ACT_TICK, 7'd127, 7'd127);
      issue_command(ACT_TICK, 7'd42, 7'd85);
      play_random(70);

      // Synthesized voices, a held factor just under one, instant silence when
      // released, and a zero threshold: nothing is ever removed, so the
      // table fills up and further note-ons are dropped.
      program_envelope(1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
      play_random(80);

      // The opposite extremes: only a full-scale voice that does not decay
      // can stay at the top threshold, so most ticks end empty.
      program_envelope(1'b1, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      play_random(40);

      // Moderate settings with a long stretch free of idle cycles.
      program_envelope(1'b0, 16'd60000, 16'd40000, 16'd50000, 16'd2000);
      calm = 1'b1;
      play_random(80);
      calm = 1'b0;

      // Two phases with random settings whose voices live for a while.
      program_envelope(1'($urandom_range(1)), 16'($urandom_range(50000, 65535)),
                       16'($urandom_range(50000, 65535)), 16'($urandom_range(50000, 65535)),
                       16'($urandom_range(0, 3000)));
      play_random(70);
      program_envelope(1'($urandom_range(1)), 16'($urandom_range(55000, 65535)),
                       16'($urandom_range(45000, 65535)), 16'($urandom_range(45000, 65535)),
                       16'($urandom_range(0, 1500)));
      play_random(70);

      // Let the last results come home, then give the verdict.
      drain_block();
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
